// File: rtl/sct_pkg.sv
package sct_pkg;

	localparam int OUT_W = 8;

	// coordinate differences formed in the first stage
	localparam int NDIFF   = 16;
	localparam int D_BA_X  = 0;
	localparam int D_BA_Y  = 1;
	localparam int D_CA_X  = 2;
	localparam int D_CA_Y  = 3;
	localparam int D_DA_X  = 4;
	localparam int D_DA_Y  = 5;
	localparam int D_DC_X  = 6;
	localparam int D_DC_Y  = 7;
	localparam int D_AC_X  = 8;
	localparam int D_AC_Y  = 9;
	localparam int D_BC_X  = 10;
	localparam int D_BC_Y  = 11;
	localparam int D_US_X  = 12;
	localparam int D_US_Y  = 13;
	localparam int D_VS_X  = 14;
	localparam int D_VS_Y  = 15;

	// products: orientation terms in pairs, then the two dot terms
	localparam int NPROD = 10;
	localparam int MUL_A [NPROD] = '{D_BA_X, D_BA_Y, D_BA_X, D_BA_Y, D_DC_X,
		D_DC_Y, D_DC_X, D_DC_Y, D_US_X, D_US_Y};
	localparam int MUL_B [NPROD] = '{D_CA_Y, D_CA_X, D_DA_Y, D_DA_X, D_AC_Y,
		D_AC_X, D_BC_Y, D_BC_X, D_VS_X, D_VS_Y};

	// signed sums
	localparam int NRES  = 5;
	localparam int R_X   = 0; // orient(A,B,C)
	localparam int R_Y   = 1; // orient(A,B,D)
	localparam int R_Z   = 2; // orient(C,D,A)
	localparam int R_W   = 3; // orient(C,D,B)
	localparam int R_DOT = 4;

	// bounding box hits
	localparam int BOX_C_AB = 0;
	localparam int BOX_D_AB = 1;
	localparam int BOX_A_CD = 2;
	localparam int BOX_B_CD = 3;

	typedef struct packed {
		logic       both_shared;
		logic       one_shared;
		logic       v_is_c;
		logic [3:0] box;
	} ctl_t;

	typedef struct packed {
		logic [NRES-1:0] neg;
		logic [NRES-1:0] zero;
	} sgn_t;

endpackage

// File: rtl/segment_conflict_test.sv
// Segment conflict test: pairwise check of two segments AB and CD.
// Input channel s_*: one transfer carries four point indices and the eight
// coordinates of A, B, C and D. Output channel m_*: one transfer per input
// carrying a single conflict flag, in input order.
// Four register stages: difference/compare, multiply (ten COORD_BITS+1
// squared multipliers), sum and sign, decision into the output register.
// Throughput is one item per clock while m_tready stays high; every stage is
// a register stage with its own valid bit, so a new item is taken each cycle.
// When m_tready is low the output holds its transfer; the stages behind it
// keep filling any empty slots, and s_tready drops only once all four stages
// hold items. Nothing is dropped or repeated under stalls.
// Reset (arst_n low) clears all valid bits; no result is pending afterwards.
// Point indices are only compared for equality; a shared endpoint takes the
// coordinates carried with segment AB.
module segment_conflict_test #(
	parameter int COORD_BITS = 32,
	parameter int MAX_POINTS = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// index_a, index_b, index_c, index_d, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y
	input  logic [((4*$clog2(MAX_POINTS)+8*COORD_BITS+7)/8)*8-1:0] s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// segments_conflict, zero fill
	output logic [sct_pkg::OUT_W-1:0] m_tdata
);
	import sct_pkg::*;

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int C0    = 4 * IDX_W;

	logic                            en1, en2, en3, en4;
	logic                            valid_s1, valid_s2, valid_s3, valid_s4;
	logic [NDIFF-1:0][COORD_BITS:0]  diff_s1;
	logic [NPROD-1:0][2*COORD_BITS+1:0] prod_s2;
	ctl_t                            ctl_s1, ctl_s2, ctl_s3;
	sgn_t                            sgn_s3;
	logic                            conflict, conflict_s4;
	logic                            shared_zero, dot_pos, crossing, touch;

	assign en4      = !valid_s4 || m_tready;
	assign en3      = !valid_s3 || en4;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign s_tready = en1;

	sct_diff #(.COORD_BITS(COORD_BITS), .IDX_W(IDX_W)) u_diff (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en1),
		.in_valid (s_tvalid),
		.index_a  (s_tdata[0*IDX_W +: IDX_W]),
		.index_b  (s_tdata[1*IDX_W +: IDX_W]),
		.index_c  (s_tdata[2*IDX_W +: IDX_W]),
		.index_d  (s_tdata[3*IDX_W +: IDX_W]),
		.a_x      ($signed(s_tdata[C0+0*COORD_BITS +: COORD_BITS])),
		.a_y      ($signed(s_tdata[C0+1*COORD_BITS +: COORD_BITS])),
		.b_x      ($signed(s_tdata[C0+2*COORD_BITS +: COORD_BITS])),
		.b_y      ($signed(s_tdata[C0+3*COORD_BITS +: COORD_BITS])),
		.c_x      ($signed(s_tdata[C0+4*COORD_BITS +: COORD_BITS])),
		.c_y      ($signed(s_tdata[C0+5*COORD_BITS +: COORD_BITS])),
		.d_x      ($signed(s_tdata[C0+6*COORD_BITS +: COORD_BITS])),
		.d_y      ($signed(s_tdata[C0+7*COORD_BITS +: COORD_BITS])),
		.valid_s1 (valid_s1),
		.diff_s1  (diff_s1),
		.ctl_s1   (ctl_s1)
	);

	sct_mul #(.COORD_BITS(COORD_BITS)) u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en2),
		.valid_s1 (valid_s1),
		.diff_s1  (diff_s1),
		.ctl_s1   (ctl_s1),
		.valid_s2 (valid_s2),
		.prod_s2  (prod_s2),
		.ctl_s2   (ctl_s2)
	);

	sct_sign #(.COORD_BITS(COORD_BITS)) u_sign (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en3),
		.valid_s2 (valid_s2),
		.prod_s2  (prod_s2),
		.ctl_s2   (ctl_s2),
		.valid_s3 (valid_s3),
		.sgn_s3   (sgn_s3),
		.ctl_s3   (ctl_s3)
	);

	// orient(B,A,V) is the negation of orient(A,B,V): zero test reuses X/Y
	always_comb begin
		shared_zero = ctl_s3.v_is_c ? sgn_s3.zero[R_X] : sgn_s3.zero[R_Y];
		dot_pos     = !sgn_s3.neg[R_DOT] && !sgn_s3.zero[R_DOT];
		crossing    = !sgn_s3.zero[R_X] && !sgn_s3.zero[R_Y] &&
			(sgn_s3.neg[R_X] ^ sgn_s3.neg[R_Y]) &&
			!sgn_s3.zero[R_Z] && !sgn_s3.zero[R_W] &&
			(sgn_s3.neg[R_Z] ^ sgn_s3.neg[R_W]);
		touch       = (sgn_s3.zero[R_X] && ctl_s3.box[BOX_C_AB]) ||
			(sgn_s3.zero[R_Y] && ctl_s3.box[BOX_D_AB]) ||
			(sgn_s3.zero[R_Z] && ctl_s3.box[BOX_A_CD]) ||
			(sgn_s3.zero[R_W] && ctl_s3.box[BOX_B_CD]);
		if (ctl_s3.both_shared) begin
			conflict = 1'b1;
		end else if (ctl_s3.one_shared) begin
			conflict = shared_zero && dot_pos;
		end else begin
			conflict = crossing || touch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			conflict_s4 <= conflict;
		end
	end

	assign m_tvalid = valid_s4;
	assign m_tdata  = {{(OUT_W-1){1'b0}}, conflict_s4};

endmodule

// File: rtl/sct_diff.sv
module sct_diff #(
	parameter int COORD_BITS = 32,
	parameter int IDX_W      = 10
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  logic [IDX_W-1:0]                       index_a,
	input  logic [IDX_W-1:0]                       index_b,
	input  logic [IDX_W-1:0]                       index_c,
	input  logic [IDX_W-1:0]                       index_d,
	input  logic signed [COORD_BITS-1:0]           a_x,
	input  logic signed [COORD_BITS-1:0]           a_y,
	input  logic signed [COORD_BITS-1:0]           b_x,
	input  logic signed [COORD_BITS-1:0]           b_y,
	input  logic signed [COORD_BITS-1:0]           c_x,
	input  logic signed [COORD_BITS-1:0]           c_y,
	input  logic signed [COORD_BITS-1:0]           d_x,
	input  logic signed [COORD_BITS-1:0]           d_y,
	output logic                                   valid_s1,
	output logic [sct_pkg::NDIFF-1:0][COORD_BITS:0] diff_s1,
	output sct_pkg::ctl_t                          ctl_s1
);
	import sct_pkg::*;

	localparam int DW = COORD_BITS + 1;

	function automatic logic signed [DW-1:0] sub(input logic signed [COORD_BITS-1:0] p,
		input logic signed [COORD_BITS-1:0] q);
		sub = DW'(p) - DW'(q);
	endfunction

	function automatic logic in_rng(input logic signed [COORD_BITS-1:0] p,
		input logic signed [COORD_BITS-1:0] q, input logic signed [COORD_BITS-1:0] r);
		in_rng = ((p <= r) && (r <= q)) || ((q <= r) && (r <= p));
	endfunction

	logic                            sh_a, sh_b, sel_b, v_c;
	logic [IDX_W-1:0]                id_sh;
	logic signed [COORD_BITS-1:0]    s_x, s_y, u_x, u_y, v_x, v_y;
	logic [NDIFF-1:0][DW-1:0]        d;
	ctl_t                            ctl;

	always_comb begin
		sh_a  = (index_a == index_c) || (index_a == index_d);
		sh_b  = (index_b == index_c) || (index_b == index_d);
		sel_b = !sh_a;
		id_sh = sel_b ? index_b : index_a;
		v_c   = (index_c != id_sh);
		s_x   = sel_b ? b_x : a_x;
		s_y   = sel_b ? b_y : a_y;
		u_x   = sel_b ? a_x : b_x;
		u_y   = sel_b ? a_y : b_y;
		v_x   = v_c ? c_x : d_x;
		v_y   = v_c ? c_y : d_y;

		d[D_BA_X] = sub(b_x, a_x);
		d[D_BA_Y] = sub(b_y, a_y);
		d[D_CA_X] = sub(c_x, a_x);
		d[D_CA_Y] = sub(c_y, a_y);
		d[D_DA_X] = sub(d_x, a_x);
		d[D_DA_Y] = sub(d_y, a_y);
		d[D_DC_X] = sub(d_x, c_x);
		d[D_DC_Y] = sub(d_y, c_y);
		d[D_AC_X] = sub(a_x, c_x);
		d[D_AC_Y] = sub(a_y, c_y);
		d[D_BC_X] = sub(b_x, c_x);
		d[D_BC_Y] = sub(b_y, c_y);
		d[D_US_X] = sub(u_x, s_x);
		d[D_US_Y] = sub(u_y, s_y);
		d[D_VS_X] = sub(v_x, s_x);
		d[D_VS_Y] = sub(v_y, s_y);

		ctl.both_shared   = sh_a && sh_b;
		ctl.one_shared    = sh_a ^ sh_b;
		ctl.v_is_c        = v_c;
		ctl.box[BOX_C_AB] = in_rng(a_x, b_x, c_x) && in_rng(a_y, b_y, c_y);
		ctl.box[BOX_D_AB] = in_rng(a_x, b_x, d_x) && in_rng(a_y, b_y, d_y);
		ctl.box[BOX_A_CD] = in_rng(c_x, d_x, a_x) && in_rng(c_y, d_y, a_y);
		ctl.box[BOX_B_CD] = in_rng(c_x, d_x, b_x) && in_rng(c_y, d_y, b_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= d;
			ctl_s1  <= ctl;
		end
	end

endmodule

// File: rtl/sct_mul.sv
module sct_mul #(
	parameter int COORD_BITS = 32
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           en,
	input  logic                                           valid_s1,
	input  logic [sct_pkg::NDIFF-1:0][COORD_BITS:0]         diff_s1,
	input  sct_pkg::ctl_t                                  ctl_s1,
	output logic                                           valid_s2,
	output logic [sct_pkg::NPROD-1:0][2*COORD_BITS+1:0]     prod_s2,
	output sct_pkg::ctl_t                                  ctl_s2
);
	import sct_pkg::*;

	localparam int PW = 2 * (COORD_BITS + 1);

	logic [NPROD-1:0][PW-1:0] p;

	for (genvar k = 0; k < NPROD; k++) begin : g_mul
		logic signed [PW-1:0] m;
		assign m    = $signed(diff_s1[MUL_A[k]]) * $signed(diff_s1[MUL_B[k]]);
		assign p[k] = m;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= p;
			ctl_s2  <= ctl_s1;
		end
	end

endmodule

// File: rtl/sct_sign.sv
module sct_sign #(
	parameter int COORD_BITS = 32
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           en,
	input  logic                                           valid_s2,
	input  logic [sct_pkg::NPROD-1:0][2*COORD_BITS+1:0]     prod_s2,
	input  sct_pkg::ctl_t                                  ctl_s2,
	output logic                                           valid_s3,
	output sct_pkg::sgn_t                                  sgn_s3,
	output sct_pkg::ctl_t                                  ctl_s3
);
	import sct_pkg::*;

	localparam int PW = 2 * (COORD_BITS + 1);
	localparam int RW = PW + 1;

	function automatic logic signed [RW-1:0] ext(input logic [PW-1:0] v);
		ext = RW'($signed(v));
	endfunction

	logic [NRES-1:0][RW-1:0] r;
	sgn_t                    sgn;

	always_comb begin
		r[R_X]   = ext(prod_s2[0]) - ext(prod_s2[1]);
		r[R_Y]   = ext(prod_s2[2]) - ext(prod_s2[3]);
		r[R_Z]   = ext(prod_s2[4]) - ext(prod_s2[5]);
		r[R_W]   = ext(prod_s2[6]) - ext(prod_s2[7]);
		r[R_DOT] = ext(prod_s2[8]) + ext(prod_s2[9]);
		for (int k = 0; k < NRES; k++) begin
			sgn.neg[k]  = r[k][RW-1];
			sgn.zero[k] = (r[k] == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s3 <= sgn;
			ctl_s3 <= ctl_s2;
		end
	end

endmodule

// File: rtl/sct_check.sv
module sct_check #(
	parameter int COORD_BITS = 32,
	parameter int MAX_POINTS = 1024
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic [((4*$clog2(MAX_POINTS)+8*COORD_BITS+7)/8)*8-1:0] s_tdata,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [sct_pkg::OUT_W-1:0] m_tdata
);
	import sct_pkg::*;

	localparam int IDX_W = $clog2(MAX_POINTS);

	logic acc_both;

	assign acc_both = s_tvalid && s_tready &&
		(s_tdata[0*IDX_W +: IDX_W] == s_tdata[2*IDX_W +: IDX_W]) &&
		(s_tdata[1*IDX_W +: IDX_W] == s_tdata[3*IDX_W +: IDX_W]);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output transfer changed while stalled");

	a_ready_only_on_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_W-1:1] == '0)
		else $error("output pad bits not zero");

	a_shared_both: assert property (@(posedge clk) disable iff (!arst_n)
		acc_both ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid && m_tdata[0])
		else $error("segments sharing both endpoints not flagged after four cycles");

endmodule

bind segment_conflict_test sct_check #(
	.COORD_BITS (COORD_BITS),
	.MAX_POINTS (MAX_POINTS)
) u_sct_check (.*);
